// ===== rtl/core/sv39ptu_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39ptu_pkg - shared types and constants
// codes, entry layout constants and sequencer states of the page table updater
// ----------------------------------------------------------------------------
package sv39ptu_pkg;

  localparam int IDX_W     = 9;
  localparam int PPN_W     = 44;
  localparam int VPN_W     = 27;
  localparam int ENTRY_W   = 64;
  localparam int COUNT_W   = 7;
  localparam int RESULT_MAX = 64;
  localparam int FREE_W    = 9;

  typedef enum logic [1:0] {
    CMD_MAP     = 2'd0,
    CMD_UNMAP   = 2'd1,
    CMD_PROTECT = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ALLOC,
    S_LINK,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/sv39_page_table_updater_top.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_updater_top - three-level sv39 page table engine
// ----------------------------------------------------------------------------
// Each input word is one command (map, unmap, protect, query) over a run of
// up to 64 consecutive pages; one result word comes out per page, the final
// one flagged by out_last. The block works on one input word at a time and
// in_ready is low from acceptance until the last result has been loaded into
// the output register. A page walk is a small sequencer around one table
// store port: every level passes through a read state and an evaluate
// state, and each page then hands its result over in a finish state, which
// waits while the output register holds a stalled word. A map that meets
// an invalid entry above level 0 allocates a table page, whose 512 entries
// are swept to zero before the pointer to it is written. After reset the
// whole store is swept to zero, during which no input word is taken;
// configuration writes are always taken.
// ----------------------------------------------------------------------------
module sv39_page_table_updater_top #(
  parameter int TABLE_PAGES = 16,
  parameter int MAX_RUN     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [26:0] in_virtual_page,
  input  logic [43:0] in_physical_page,
  input  logic [3:0]  in_permissions,
  input  logic [6:0]  in_page_count,
  input  logic        in_release_frames,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [43:0] out_frame_page,
  output logic        out_release_valid,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [43:0] cfg_table_base_ppn
);
  import sv39ptu_pkg::*;

  localparam int SLOT_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW        = SLOT_W + IDX_W;
  localparam int DEPTH     = TABLE_PAGES * (1 << IDX_W);
  localparam int RUN_LIMIT = (MAX_RUN < RESULT_MAX) ? MAX_RUN : RESULT_MAX;

  // sequencer state
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [VPN_W-1:0]    vpn_r, vpn_nxt;
  logic [PPN_W-1:0]    ppn_r, ppn_nxt;
  logic [3:0]          perm_r, perm_nxt;
  logic                rel_r, rel_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [1:0]          level_r, level_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   alloc_slot_r, alloc_slot_nxt;
  logic [FREE_W-1:0]   next_free_r, next_free_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [PPN_W-1:0]    base_r, base_nxt;

  // per-page result waiting for the output register
  status_t             res_status_r, res_status_nxt;
  logic [PPN_W-1:0]    res_frame_r, res_frame_nxt;
  logic                res_rel_r, res_rel_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [PPN_W-1:0]    out_frame_r, out_frame_nxt;
  logic                out_rel_r, out_rel_nxt;
  logic                out_last_r, out_last_nxt;

  // store port and shared adder
  logic                we;
  logic [AW-1:0]       waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [AW-1:0]       addr;
  logic [ENTRY_W-1:0]  entry;
  logic [IDX_W-1:0]    idx;
  logic [PPN_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_sub, alu_in_store;
  logic                e_valid, e_leaf;
  logic [COUNT_W-1:0]  run_len;

  sv39ptu_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (entry)
  );

  sv39ptu_ppn_unit #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_ppn (
    .a        (alu_a),
    .b        (alu_b),
    .sub      (alu_sub),
    .res      (alu_res),
    .in_store (alu_in_store)
  );

  // 9-bit index of the current level
  always_comb begin
    case (level_r)
      2'd2:    idx = vpn_r[3*IDX_W-1:2*IDX_W];
      2'd1:    idx = vpn_r[2*IDX_W-1:IDX_W];
      default: idx = vpn_r[IDX_W-1:0];
    endcase
  end

  assign addr    = {slot_r, idx};
  assign e_valid = entry[0];
  // any rwx bit makes a leaf; level 0 treats every valid entry as a leaf
  assign e_leaf  = (entry[3:1] != 3'd0) || (level_r == 2'd0);

  // adder adds base + new slot while linking, else pointer ppn - base
  assign alu_sub = (state_r != S_LINK);
  assign alu_a   = (state_r == S_LINK) ? base_r : entry[10 +: PPN_W];
  assign alu_b   = (state_r == S_LINK) ? PPN_W'(alloc_slot_r) : base_r;

  // run length saturated to the result limit
  assign run_len = (in_page_count > COUNT_W'(RUN_LIMIT)) ? COUNT_W'(RUN_LIMIT)
                                                         : in_page_count;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    vpn_nxt        = vpn_r;
    ppn_nxt        = ppn_r;
    perm_nxt       = perm_r;
    rel_nxt        = rel_r;
    rem_nxt        = rem_r;
    level_nxt      = level_r;
    slot_nxt       = slot_r;
    alloc_slot_nxt = alloc_slot_r;
    next_free_nxt  = next_free_r;
    clr_nxt        = clr_r;
    base_nxt       = base_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    res_rel_nxt    = res_rel_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_rel_nxt    = out_rel_r;
    out_last_nxt   = out_last_r;
    we             = 1'b0;
    waddr          = addr;
    wdata          = '0;
    in_ready       = 1'b0;

    if (cfg_valid) begin
      base_nxt = cfg_table_base_ppn;
    end

    case (state_r)
      // post-reset sweep of the whole store
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          vpn_nxt   = in_virtual_page;
          ppn_nxt   = in_physical_page;
          perm_nxt  = in_permissions;
          rel_nxt   = in_release_frames;
          rem_nxt   = run_len;
          level_nxt = 2'd2;
          slot_nxt  = '0;
          if (run_len != '0) begin
            state_nxt = S_READ;
          end
        end
      end

      // store read issued, data registered for next cycle
      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        res_frame_nxt  = '0;
        res_rel_nxt    = 1'b0;
        res_status_nxt = ST_OK;
        state_nxt      = S_FINISH;
        if (cmd_r == CMD_MAP) begin
          if (e_valid && !e_leaf) begin
            if (alu_in_store) begin
              slot_nxt  = alu_res[SLOT_W-1:0];
              level_nxt = level_r - 2'd1;
              state_nxt = S_READ;
            end else begin
              res_status_nxt = ST_EXHAUSTED;
            end
          end else if (e_valid || level_r == 2'd0) begin
            // overwrite leaf or fill empty level 0 slot
            we    = 1'b1;
            wdata = {10'b0, ppn_r, 6'b0, perm_r | 4'b0001};
          end else if (next_free_r >= FREE_W'(TABLE_PAGES)) begin
            res_status_nxt = ST_EXHAUSTED;
          end else begin
            alloc_slot_nxt = next_free_r[SLOT_W-1:0];
            next_free_nxt  = next_free_r + 1'b1;
            clr_nxt        = '0;
            state_nxt      = S_ALLOC;
          end
        end else begin
          if (!e_valid) begin
            res_status_nxt = ST_NOT_MAPPED;
          end else if (e_leaf) begin
            case (cmd_r)
              CMD_UNMAP: begin
                we            = 1'b1;
                wdata         = {entry[63:1], 1'b0};
                res_frame_nxt = entry[10 +: PPN_W];
                res_rel_nxt   = rel_r;
              end
              CMD_PROTECT: begin
                we    = 1'b1;
                wdata = {entry[63:4], perm_r | 4'b0001};
              end
              default: begin
              end
            endcase
          end else if (alu_in_store) begin
            slot_nxt  = alu_res[SLOT_W-1:0];
            level_nxt = level_r - 2'd1;
            state_nxt = S_READ;
          end else begin
            res_status_nxt = ST_NOT_MAPPED;
          end
        end
      end

      // zero the freshly allocated table page
      S_ALLOC: begin
        we      = 1'b1;
        waddr   = {alloc_slot_r, clr_r[IDX_W-1:0]};
        clr_nxt = clr_r + 1'b1;
        if (clr_r[IDX_W-1:0] == {IDX_W{1'b1}}) begin
          clr_nxt   = '0;
          state_nxt = S_LINK;
        end
      end

      // pointer to the new page, then descend into it
      S_LINK: begin
        we        = 1'b1;
        wdata     = {10'b0, alu_res, 9'b0, 1'b1};
        slot_nxt  = alloc_slot_r;
        level_nxt = level_r - 2'd1;
        state_nxt = S_READ;
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          out_rel_nxt    = res_rel_r;
          out_last_nxt   = (rem_r == COUNT_W'(1));
          if (rem_r == COUNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = rem_r - 1'b1;
            vpn_nxt   = vpn_r + 1'b1;
            ppn_nxt   = ppn_r + 1'b1;
            level_nxt = 2'd2;
            slot_nxt  = '0;
            state_nxt = S_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      next_free_r <= FREE_W'(1);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_free_r <= next_free_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    vpn_r        <= vpn_nxt;
    ppn_r        <= ppn_nxt;
    perm_r       <= perm_nxt;
    rel_r        <= rel_nxt;
    rem_r        <= rem_nxt;
    level_r      <= level_nxt;
    slot_r       <= slot_nxt;
    alloc_slot_r <= alloc_slot_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    res_rel_r    <= res_rel_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_rel_r    <= out_rel_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_page    = out_frame_r;
  assign out_release_valid = out_rel_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/core/sv39ptu_store.sv =====
// ----------------------------------------------------------------------------
// sv39ptu_store - table store
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module sv39ptu_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sv39ptu_ppn_unit.sv =====
// ----------------------------------------------------------------------------
// sv39ptu_ppn_unit - shared page number adder
// subtracts for pointer to slot translation, adds for slot to pointer
// ----------------------------------------------------------------------------
module sv39ptu_ppn_unit #(
  parameter int TABLE_PAGES = 16
) (
  input  logic [sv39ptu_pkg::PPN_W-1:0] a,
  input  logic [sv39ptu_pkg::PPN_W-1:0] b,
  input  logic                          sub,
  output logic [sv39ptu_pkg::PPN_W-1:0] res,
  output logic                          in_store
);
  import sv39ptu_pkg::*;

  always_comb begin
    if (sub) begin
      res = a - b;
    end else begin
      res = a + b;
    end
    // slot number must name a page of the store
    in_store = (res < PPN_W'(TABLE_PAGES));
  end

endmodule

// ===== rtl/core/sv39ptu_checker.sv =====
// ----------------------------------------------------------------------------
// sv39ptu_checker - port level checks
// watches the top level ports of the page table updater
// ----------------------------------------------------------------------------
module sv39ptu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [6:0]  in_page_count,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [43:0] out_frame_page,
  input logic        out_release_valid,
  input logic        out_last
);
  import sv39ptu_pkg::*;

  // one word in flight: ready drops after an accepted word with pages
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_page_count != 7'd0) |=> !in_ready)
    else $error("input taken while a run is in progress");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_frame_page) && $stable(out_last))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_NOT_MAPPED) ||
      (out_status == ST_EXHAUSTED))
    else $error("undefined status code");

  // release only reported on a successful unmap
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_release_valid |-> out_status == ST_OK)
    else $error("release reported on a failed page");

endmodule

bind sv39_page_table_updater_top sv39ptu_checker u_sv39ptu_checker (.*);
